/* rtl/btks_pkg.sv */
package btks_pkg;

   localparam int SCORE_W     = 32;
   localparam int TIE_W       = 64;
   localparam int SEQ_W       = 32;
   localparam int REF_FIELD_W = 32;
   localparam int OUTCOME_W   = 3;
   localparam int BW_W        = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 7;

   localparam int REQ_SCORE_LSB = 0;
   localparam int REQ_TIE_LSB   = REQ_SCORE_LSB + SCORE_W;
   localparam int REQ_REF_LSB   = REQ_TIE_LSB + TIE_W;
   localparam int REQ_DATA_W    = REQ_REF_LSB + REF_FIELD_W;
   localparam int REQ_USER_W    = 1;
   localparam int RSP_DATA_W    = REF_FIELD_W + SCORE_W;

   localparam logic [SEQ_W-1:0] SEQ_MAX  = '1;
   localparam logic [BW_W-1:0]  BW_RESET = 7'd64;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_ACCEPT = 3'd0,
      OUT_REJECT = 3'd1,
      OUT_EVICT  = 3'd2,
      OUT_DRAIN  = 3'd3,
      OUT_EMPTY  = 3'd4
   } outcome_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PREFER_HIGHER  = 2'd0,
      CSR_RANDOMIZE_TIES = 2'd1,
      CSR_BEAM_WIDTH     = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      RD_WORST,
      RD_IDX,
      RD_SH_PREV
   } rd_sel_type;

   typedef enum logic [1:0] {
      SRC_NEW,
      SRC_EVICT,
      SRC_RD,
      SRC_ZERO
   } out_src_type;

   typedef struct packed {
      logic        load_item;
      logic        arrival_inc;
      logic        arrival_clear;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_new;
      logic        wr_shift;
      logic        idx_clear;
      logic        idx_inc;
      logic        sh_load;
      logic        sh_evict;
      logic        sh_dec;
      logic        ev_capture;
      logic        fill_inc;
      logic        fill_clear;
      logic        out_load;
      out_src_type out_src;
      outcome_type out_code;
      logic        out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic fill_zero;
      logic idx_at_fill;
      logic idx_at_last;
      logic sh_at_idx;
      logic new_before_rd;
      logic rd_before_new;
      logic out_free;
   } dp_status_type;

   // true when candidate a ranks strictly ahead of candidate b
   function automatic logic ranks_before(
      input logic                      prefer_higher,
      input logic                      randomize_ties,
      input logic signed [SCORE_W-1:0] sa,
      input logic        [TIE_W-1:0]   ta,
      input logic        [SEQ_W-1:0]   qa,
      input logic signed [SCORE_W-1:0] sb,
      input logic        [TIE_W-1:0]   tb,
      input logic        [SEQ_W-1:0]   qb
   );
      logic r;
      if (sa != sb) begin
         r = prefer_higher ? (sa > sb) : (sa < sb);
      end else if (randomize_ties && (ta != tb)) begin
         r = ta < tb;
      end else begin
         r = qa < qb;
      end
      return r;
   endfunction

endpackage

/* rtl/btks_ctrl.sv */
module btks_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_cmd,
   output logic                   req_tready,
   input  btks_pkg::dp_status_type status,
   output btks_pkg::dp_cmd_type    cmd
);
   import btks_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHK_RD,
      S_CHK_CMP,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHF_RD,
      S_SHF_WR,
      S_FIN,
      S_REJ,
      S_DRN_RD,
      S_DRN_OUT,
      S_EMPTY
   } state_type;

   state_type state_ff, state_in;
   logic      evict_ff, evict_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         evict_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         evict_ff <= evict_in;
      end
   end

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      evict_in   = evict_ff;
      req_tready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               cmd.idx_clear = 1'b1;
               if (req_cmd == CMD_DRAIN) begin
                  state_in = status.fill_zero ? S_EMPTY : S_DRN_RD;
               end else begin
                  cmd.arrival_inc = 1'b1;
                  evict_in        = 1'b0;
                  if (status.full) begin
                     state_in = S_CHK_RD;
                  end else begin
                     cmd.sh_load = 1'b1;
                     state_in    = S_SCAN_RD;
                  end
               end
            end
         end
         S_CHK_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_WORST;
            state_in   = S_CHK_CMP;
         end
         S_CHK_CMP: begin
            if (!status.new_before_rd) begin
               state_in = S_REJ;
            end else begin
               cmd.ev_capture = 1'b1;
               cmd.sh_load    = 1'b1;
               cmd.sh_evict   = 1'b1;
               evict_in       = 1'b1;
               state_in       = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (status.idx_at_fill) begin
               state_in = S_SHF_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX;
               state_in   = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (status.rd_before_new) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end else begin
               state_in = S_SHF_RD;
            end
         end
         S_SHF_RD: begin
            if (status.sh_at_idx) begin
               cmd.wr_new   = 1'b1;
               cmd.fill_inc = !evict_ff;
               state_in     = S_FIN;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_SH_PREV;
               state_in   = S_SHF_WR;
            end
         end
         S_SHF_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.sh_dec   = 1'b1;
            state_in     = S_SHF_RD;
         end
         S_FIN: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = evict_ff ? SRC_EVICT : SRC_NEW;
               cmd.out_code = evict_ff ? OUT_EVICT : OUT_ACCEPT;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_REJ: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_NEW;
               cmd.out_code = OUT_REJECT;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_DRN_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_DRN_OUT;
         end
         S_DRN_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_RD;
               cmd.out_code = OUT_DRAIN;
               cmd.out_last = status.idx_at_last;
               if (status.idx_at_last) begin
                  cmd.fill_clear    = 1'b1;
                  cmd.arrival_clear = 1'b1;
                  state_in          = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_DRN_RD;
               end
            end
         end
         S_EMPTY: begin
            if (status.out_free) begin
               cmd.out_load      = 1'b1;
               cmd.out_src       = SRC_ZERO;
               cmd.out_code      = OUT_EMPTY;
               cmd.out_last      = 1'b1;
               cmd.arrival_clear = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/btks_dp.sv */
module btks_dp #(
   parameter int MAX_WIDTH = 64,
   parameter int REF_BITS  = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [btks_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [btks_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [btks_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  btks_pkg::dp_cmd_type               cmd,
   output btks_pkg::dp_status_type            status,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [btks_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [btks_pkg::OUTCOME_W-1:0]     rsp_tuser,
   output logic                               rsp_tlast
);
   import btks_pkg::*;

   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
   localparam int REF_W  = (REF_BITS < REF_FIELD_W) ? REF_BITS : REF_FIELD_W;
   localparam int CMP_W  = (CNT_W > BW_W) ? CNT_W : BW_W;

   // configuration
   logic            prefer_higher_ff;
   logic            randomize_ties_ff;
   logic [BW_W-1:0] beam_width_ff;

   // counters
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [SEQ_W-1:0] arrival_ff, arrival_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] sh_ff, sh_in;

   // candidate being inserted
   logic signed [SCORE_W-1:0] new_score_ff;
   logic        [TIE_W-1:0]   new_tie_ff;
   logic        [SEQ_W-1:0]   new_seq_ff;
   logic        [REF_W-1:0]   new_ref_ff;

   // dropped worst entry
   logic signed [SCORE_W-1:0] ev_score_ff;
   logic        [REF_W-1:0]   ev_ref_ff;

   // store and its read data
   logic signed [SCORE_W-1:0] mem_score [MAX_WIDTH];
   logic        [TIE_W-1:0]   mem_tie   [MAX_WIDTH];
   logic        [SEQ_W-1:0]   mem_seq   [MAX_WIDTH];
   logic        [REF_W-1:0]   mem_ref   [MAX_WIDTH];
   logic signed [SCORE_W-1:0] rd_score_ff;
   logic        [TIE_W-1:0]   rd_tie_ff;
   logic        [SEQ_W-1:0]   rd_seq_ff;
   logic        [REF_W-1:0]   rd_ref_ff;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OUTCOME_W-1:0]      rsp_code_ff;
   logic [REF_FIELD_W-1:0]    rsp_ref_ff;
   logic [SCORE_W-1:0]        rsp_score_ff;
   logic                      rsp_last_ff;

   logic [CMP_W-1:0] bw_ext;
   logic [CNT_W-1:0] width_eff;
   logic [CNT_W-1:0] fill_m1;
   logic [CNT_W-1:0] sh_m1;
   logic [CNT_W-1:0] rd_pos;
   logic [CNT_W-1:0] wr_pos;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_en;
   logic signed [SCORE_W-1:0] wr_score;
   logic        [TIE_W-1:0]   wr_tie;
   logic        [SEQ_W-1:0]   wr_seq;
   logic        [REF_W-1:0]   wr_ref;
   logic              out_free;
   logic [REF_FIELD_W-1:0]    out_ref;
   logic [SCORE_W-1:0]        out_score;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefer_higher_ff  <= 1'b0;
         randomize_ties_ff <= 1'b0;
         beam_width_ff     <= BW_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PREFER_HIGHER:  prefer_higher_ff  <= csr_wdata[0];
            CSR_RANDOMIZE_TIES: randomize_ties_ff <= csr_wdata[0];
            CSR_BEAM_WIDTH:     beam_width_ff     <= csr_wdata[BW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // zero acts as one, anything above the store depth acts as the depth
   assign bw_ext = CMP_W'(beam_width_ff);

   always_comb begin
      priority if (bw_ext == '0) begin
         width_eff = CNT_W'(1);
      end else if (bw_ext > CMP_W'(MAX_WIDTH)) begin
         width_eff = CNT_W'(MAX_WIDTH);
      end else begin
         width_eff = bw_ext[CNT_W-1:0];
      end
   end

   assign fill_m1 = fill_ff - CNT_W'(1);
   assign sh_m1   = sh_ff - CNT_W'(1);

   always_comb begin
      unique case (cmd.rd_sel)
         RD_WORST:   rd_pos = fill_m1;
         RD_IDX:     rd_pos = idx_ff;
         RD_SH_PREV: rd_pos = sh_m1;
         default:    rd_pos = idx_ff;
      endcase
   end

   assign rd_addr  = rd_pos[ADDR_W-1:0];
   assign wr_en    = cmd.wr_new || cmd.wr_shift;
   assign wr_pos   = cmd.wr_new ? idx_ff : sh_ff;
   assign wr_addr  = wr_pos[ADDR_W-1:0];
   assign wr_score = cmd.wr_new ? new_score_ff : rd_score_ff;
   assign wr_tie   = cmd.wr_new ? new_tie_ff   : rd_tie_ff;
   assign wr_seq   = cmd.wr_new ? new_seq_ff   : rd_seq_ff;
   assign wr_ref   = cmd.wr_new ? new_ref_ff   : rd_ref_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_score[wr_addr] <= wr_score;
         mem_tie[wr_addr]   <= wr_tie;
         mem_seq[wr_addr]   <= wr_seq;
         mem_ref[wr_addr]   <= wr_ref;
      end
      if (cmd.rd_en) begin
         rd_score_ff <= mem_score[rd_addr];
         rd_tie_ff   <= mem_tie[rd_addr];
         rd_seq_ff   <= mem_seq[rd_addr];
         rd_ref_ff   <= mem_ref[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         new_score_ff <= req_tdata[REQ_SCORE_LSB +: SCORE_W];
         new_tie_ff   <= req_tdata[REQ_TIE_LSB +: TIE_W];
         new_ref_ff   <= req_tdata[REQ_REF_LSB +: REF_W];
         new_seq_ff   <= arrival_ff;
      end
      if (cmd.ev_capture) begin
         ev_score_ff <= rd_score_ff;
         ev_ref_ff   <= rd_ref_ff;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.fill_clear) begin
         fill_in = '0;
      end else if (cmd.fill_inc) begin
         fill_in = fill_ff + CNT_W'(1);
      end
      arrival_in = arrival_ff;
      if (cmd.arrival_clear) begin
         arrival_in = '0;
      end else if (cmd.arrival_inc && (arrival_ff != SEQ_MAX)) begin
         arrival_in = arrival_ff + SEQ_W'(1);
      end
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      sh_in = sh_ff;
      if (cmd.sh_load) begin
         sh_in = cmd.sh_evict ? fill_m1 : fill_ff;
      end else if (cmd.sh_dec) begin
         sh_in = sh_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         arrival_ff <= '0;
         idx_ff     <= '0;
         sh_ff      <= '0;
      end else begin
         fill_ff    <= fill_in;
         arrival_ff <= arrival_in;
         idx_ff     <= idx_in;
         sh_ff      <= sh_in;
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      unique case (cmd.out_src)
         SRC_NEW: begin
            out_ref   = REF_FIELD_W'(new_ref_ff);
            out_score = new_score_ff;
         end
         SRC_EVICT: begin
            out_ref   = REF_FIELD_W'(ev_ref_ff);
            out_score = ev_score_ff;
         end
         SRC_RD: begin
            out_ref   = REF_FIELD_W'(rd_ref_ff);
            out_score = rd_score_ff;
         end
         default: begin
            out_ref   = '0;
            out_score = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_code_ff  <= cmd.out_code;
         rsp_ref_ff   <= out_ref;
         rsp_score_ff <= out_score;
         rsp_last_ff  <= cmd.out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_score_ff, rsp_ref_ff};
   assign rsp_tuser  = rsp_code_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign status.full          = (fill_ff >= width_eff);
   assign status.fill_zero     = (fill_ff == '0);
   assign status.idx_at_fill   = (idx_ff == fill_ff);
   assign status.idx_at_last   = (idx_ff == fill_m1);
   assign status.sh_at_idx     = (sh_ff == idx_ff);
   assign status.out_free      = out_free;
   assign status.new_before_rd = ranks_before(prefer_higher_ff, randomize_ties_ff,
                                              new_score_ff, new_tie_ff, new_seq_ff,
                                              rd_score_ff, rd_tie_ff, rd_seq_ff);
   assign status.rd_before_new = ranks_before(prefer_higher_ff, randomize_ties_ff,
                                              rd_score_ff, rd_tie_ff, rd_seq_ff,
                                              new_score_ff, new_tie_ff, new_seq_ff);

endmodule

/* rtl/beam_top_k_selector_core.sv */
// insert: worst-entry check, ending in a rejection if the candidate does not beat it, then a scan
// for the insert position, then a shift walk, one entry at a time on the store port
// drain: one result beat per stored entry, fill beats in all (one beat for an empty beam)
// one item at a time; the next item is taken once the current result is queued
// synchronous active-high reset: beam empty, arrival counter zero, width 64,
// lower scores first, tie tokens ignored; no clearing pass over the store
module beam_top_k_selector_core #(
   parameter int MAX_WIDTH = 64,
   parameter int REF_BITS  = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [btks_pkg::REQ_DATA_W-1:0]  req_tdata,   // score, tie key, candidate_ref
   input  logic [btks_pkg::REQ_USER_W-1:0]  req_tuser,   // cmd
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [btks_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // out_ref, out_score
   output logic [btks_pkg::OUTCOME_W-1:0]   rsp_tuser,   // outcome
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [btks_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [btks_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import btks_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   btks_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser[0]),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   btks_dp #(
      .MAX_WIDTH (MAX_WIDTH),
      .REF_BITS  (REF_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/btks_checker.sv */
module btks_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [btks_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [btks_pkg::OUTCOME_W-1:0]   rsp_tuser,
   input logic                             rsp_tlast
);
   import btks_pkg::*;

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // insert results and the empty marker are single-beat
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == OUT_ACCEPT || rsp_tuser == OUT_REJECT
         || rsp_tuser == OUT_EVICT || rsp_tuser == OUT_EMPTY) |-> rsp_tlast)
      else $error("single-beat result without tlast");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == OUT_EMPTY |-> rsp_tdata == '0)
      else $error("empty marker carries data");

   // no new command while a drain is still streaming
   a_drain_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == OUT_DRAIN && !rsp_tlast |-> !req_tready)
      else $error("request taken in the middle of a drain");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset did not idle the block");

endmodule

bind beam_top_k_selector_core btks_checker u_btks_checker (.*);

/* tb/tb_beam_top_k_selector_core.sv */
module tb_beam_top_k_selector_core;
   timeunit 1ns;
   timeprecision 1ps;

   import btks_pkg::*;

   localparam int BEAM_MAX    = 64;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE      = 40;
   localparam int RANDOM_GOAL = 190;
   localparam int PRINT_CAP   = 40;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      outcome_type               outcome;
      logic [REF_FIELD_W-1:0]    cand_ref;
      logic signed [SCORE_W-1:0] cand_score;
      logic                      last;
   } beam_result_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [REQ_USER_W-1:0]  req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [OUTCOME_W-1:0]   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // predictor state
   logic signed [SCORE_W-1:0] kept_score [BEAM_MAX];
   logic [TIE_W-1:0]          kept_tie   [BEAM_MAX];
   logic [SEQ_W-1:0]          kept_seq   [BEAM_MAX];
   logic [REF_FIELD_W-1:0]    kept_ref   [BEAM_MAX];
   int                        kept_count;
   logic [SEQ_W-1:0]          next_seq;
   logic                      cfg_prefer_higher;
   logic                      cfg_random_ties;
   logic [BW_W-1:0]           cfg_beam_width;

   beam_result_type pending_results[$];
   idle_mode_type   idle_mode = IDLE_NONE;
   logic            hold_rsp = 1'b0;
   int              errors;
   int              items_sent;
   int              results_checked;
   int              csr_writes;
   int              cycles;

   beam_top_k_selector_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // score, tie key, candidate_ref
      .req_tuser  (req_tuser),    // cmd
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // out_ref, out_score
      .rsp_tuser  (rsp_tuser),    // outcome
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else begin
         case (idle_mode)
            IDLE_RECEIVER: rsp_tready <= ($urandom_range(0, 99) >= 80);
            IDLE_BOTH:     rsp_tready <= ($urandom_range(0, 99) >= 15);
            default:       rsp_tready <= 1'b1;
         endcase
      end
   end

   task automatic report_mismatch(input string msg);
      if (errors < PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      errors++;
   endtask

   // result beat checker
   always @(posedge clock) begin
      beam_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected beat outcome %0d ref %h", rsp_tuser,
                                      rsp_tdata[REF_FIELD_W-1:0]));
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_tuser !== exp_r.outcome) begin
               report_mismatch($sformatf("outcome %0d, expected %0d", rsp_tuser,
                                         exp_r.outcome));
            end
            if (rsp_tdata[REF_FIELD_W-1:0] !== exp_r.cand_ref) begin
               report_mismatch($sformatf("ref %h, expected %h", rsp_tdata[REF_FIELD_W-1:0],
                                         exp_r.cand_ref));
            end
            if (rsp_tdata[REF_FIELD_W +: SCORE_W] !== exp_r.cand_score) begin
               report_mismatch($sformatf("score %h, expected %h",
                                         rsp_tdata[REF_FIELD_W +: SCORE_W], exp_r.cand_score));
            end
            if (rsp_tlast !== exp_r.last) begin
               report_mismatch($sformatf("last %b, expected %b", rsp_tlast, exp_r.last));
            end
         end
      end
   end

   // a ahead of b in beam order
   function automatic logic outranks(
      input logic signed [SCORE_W-1:0] sa, input logic [TIE_W-1:0] ta, input logic [SEQ_W-1:0] qa,
      input logic signed [SCORE_W-1:0] sb, input logic [TIE_W-1:0] tb, input logic [SEQ_W-1:0] qb
   );
      if (sa != sb) begin
         return cfg_prefer_higher ? (sa > sb) : (sa < sb);
      end
      if (cfg_random_ties && ta != tb) begin
         return ta < tb;
      end
      return qa < qb;
   endfunction

   function automatic void push_result(input outcome_type oc, input logic [REF_FIELD_W-1:0] r,
                                       input logic signed [SCORE_W-1:0] s, input logic last);
      beam_result_type b;
      b.outcome    = oc;
      b.cand_ref   = r;
      b.cand_score = s;
      b.last       = last;
      pending_results.insert(pending_results.size(), b);
   endfunction

   function automatic void predict_selection(input logic cmd, input logic signed [SCORE_W-1:0] s,
                                             input logic [TIE_W-1:0] t,
                                             input logic [REF_FIELD_W-1:0] r);
      int                        w;
      int                        pos;
      int                        top;
      logic                      evicted;
      logic [SEQ_W-1:0]          q;
      logic [REF_FIELD_W-1:0]    ev_ref;
      logic signed [SCORE_W-1:0] ev_score;
      w = int'(cfg_beam_width);
      if (w < 1) w = 1;
      if (w > BEAM_MAX) w = BEAM_MAX;
      if (cmd == CMD_DRAIN) begin
         if (kept_count == 0) begin
            push_result(OUT_EMPTY, '0, '0, 1'b1);
         end
         for (int k = 0; k < kept_count; k++) begin
            push_result(OUT_DRAIN, kept_ref[k], kept_score[k], k == kept_count - 1);
         end
         kept_count = 0;
         next_seq   = '0;
         return;
      end
      q = next_seq;
      if (next_seq != SEQ_MAX) next_seq++;
      if (kept_count >= w && kept_count > 0) begin
         if (!outranks(s, t, q, kept_score[kept_count-1], kept_tie[kept_count-1],
                       kept_seq[kept_count-1])) begin
            push_result(OUT_REJECT, r, s, 1'b1);
            return;
         end
      end
      pos = 0;
      while (pos < kept_count && outranks(kept_score[pos], kept_tie[pos], kept_seq[pos], s, t, q))
         pos++;
      top     = kept_count;
      evicted = 1'b0;
      if (top >= BEAM_MAX) begin
         top      = BEAM_MAX - 1;
         ev_ref   = kept_ref[top];
         ev_score = kept_score[top];
         evicted  = 1'b1;
      end
      for (int i = top; i > pos; i--) begin
         kept_score[i] = kept_score[i-1];
         kept_tie[i]   = kept_tie[i-1];
         kept_seq[i]   = kept_seq[i-1];
         kept_ref[i]   = kept_ref[i-1];
      end
      kept_score[pos] = s;
      kept_tie[pos]   = t;
      kept_seq[pos]   = q;
      kept_ref[pos]   = r;
      kept_count      = top + 1;
      if (!evicted && kept_count > w) begin
         kept_count--;
         ev_ref   = kept_ref[kept_count];
         ev_score = kept_score[kept_count];
         evicted  = 1'b1;
      end
      if (evicted) push_result(OUT_EVICT, ev_ref, ev_score, 1'b1);
      else         push_result(OUT_ACCEPT, r, s, 1'b1);
   endfunction

   function automatic logic sender_gap();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(0, 99) < 80;
         IDLE_BOTH:   return $urandom_range(0, 99) < 15;
         default:     return 1'b0;
      endcase
   endfunction

   // called right after a falling edge; returns right after a falling edge
   task automatic send_item(input logic cmd, input logic signed [SCORE_W-1:0] s,
                            input logic [TIE_W-1:0] t, input logic [REF_FIELD_W-1:0] r);
      while (sender_gap()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {r, t, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_selection(cmd, s, t, r);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_insert(input logic signed [SCORE_W-1:0] s, input logic [TIE_W-1:0] t,
                              input logic [REF_FIELD_W-1:0] r);
      send_item(CMD_INSERT, s, t, r);
   endtask

   task automatic send_drain();
      send_item(CMD_DRAIN, $urandom, {$urandom, $urandom}, $urandom);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_PREFER_HIGHER:  cfg_prefer_higher = data[0];
         CSR_RANDOMIZE_TIES: cfg_random_ties   = data[0];
         CSR_BEAM_WIDTH:     cfg_beam_width    = data[BW_W-1:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
   endtask

   // upper bits of the one-bit registers carry random junk
   task automatic set_config(input logic ph, input logic rt, input logic [BW_W-1:0] bw);
      wait_idle();
      csr_write(CSR_PREFER_HIGHER, {6'($urandom), ph});
      csr_write(CSR_RANDOMIZE_TIES, {6'($urandom), rt});
      csr_write(CSR_BEAM_WIDTH, bw);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2, 3:    return $urandom;
         default: return (SCORE_W)'($signed($urandom_range(0, 6)) - 3) <<< 16;
      endcase
   endfunction

   function automatic logic [TIE_W-1:0] pick_tie();
      case ($urandom_range(0, 5))
         0:       return '1;
         1, 2:    return {$urandom, $urandom};
         default: return TIE_W'($urandom_range(0, 2));
      endcase
   endfunction

   task automatic test_directed_basics();
      idle_mode = IDLE_NONE;
      send_drain();
      send_insert(32'sh7fff_ffff, '1, '1);
      send_insert(32'sh8000_0000, '0, '0);
      send_insert(32'sh0000_0000, 64'h0123_4567_89ab_cdef, 32'h1);
      send_insert(32'sh0000_0000, 64'h0000_0000_0000_0001, 32'h2);
      send_insert(32'sh0001_8000, 64'hfedc_ba98_7654_3210, 32'hdead_beef);
      send_insert(-32'sh0000_8000, '0, 32'h5555_aaaa);
      send_drain();
   endtask

   task automatic test_tie_order();
      set_config(1'b1, 1'b1, 7'd64);
      send_insert(32'sh0002_0000, 64'd5, 32'h10);
      send_insert(32'sh0002_0000, 64'd3, 32'h11);
      send_insert(32'sh0002_0000, 64'd3, 32'h12);
      send_insert(32'sh0002_0000, '1, 32'h13);
      send_insert(32'sh0002_0000, '0, 32'h14);
      send_insert(32'sh0003_0000, '1, 32'h15);
      send_drain();
   endtask

   // zero acts as one
   task automatic test_width_edges();
      set_config(1'b0, 1'b0, 7'd0);
      send_insert(32'sh0005_0000, '0, 32'h20);
      send_insert(32'sh0006_0000, '0, 32'h21);
      send_insert(32'sh0004_0000, '0, 32'h22);
      send_insert(32'sh0004_0000, '0, 32'h23);
      send_drain();
   endtask

   // store keeps its fill when the width is lowered; each insert is rejected or evicts the worst entry
   task automatic test_width_lowered();
      set_config(1'b0, 1'b0, 7'd6);
      for (int i = 0; i < 6; i++) send_insert((SCORE_W)'(i) <<< 16, '0, 32'h30 + i);
      set_config(1'b0, 1'b0, 7'd2);
      send_insert(-32'sh0001_0000, '0, 32'h40);
      send_insert(32'sh0003_8000, '0, 32'h41);
      send_insert(32'sh0009_0000, '0, 32'h42);
      send_drain();
   endtask

   task automatic test_full_beam();
      set_config(1'b1, 1'($urandom_range(0, 1)), 7'd127);
      idle_mode = IDLE_BOTH;
      for (int i = 0; i < 70; i++) send_insert(pick_score(), pick_tie(), $urandom);
      send_drain();
   endtask

   task automatic test_output_backpressure();
      set_config(1'b0, 1'b1, 7'd16);
      idle_mode = IDLE_NONE;
      fork
         begin
            @(posedge clock);
            hold_rsp = 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         begin
            for (int i = 0; i < 20; i++) send_insert(pick_score(), pick_tie(), $urandom);
            send_drain();
         end
      join
   endtask

   task automatic test_random_layers();
      int         layer;
      int         n;
      int         eff;
      int         start;
      logic [6:0] bw;
      start = items_sent;
      layer = 0;
      while (items_sent - start < RANDOM_GOAL) begin
         case ($urandom_range(0, 7))
            0:       bw = 7'd0;
            1:       bw = 7'd1;
            2:       bw = 7'd2;
            3:       bw = 7'($urandom_range(3, 8));
            4:       bw = 7'($urandom_range(9, 20));
            5:       bw = 7'd64;
            6:       bw = 7'($urandom_range(65, 127));
            default: bw = 7'($urandom_range(21, 63));
         endcase
         eff = (bw == 0) ? 1 : (bw > BEAM_MAX) ? BEAM_MAX : int'(bw);
         set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), bw);
         idle_mode = idle_mode_type'(layer % 4);
         if ($urandom_range(0, 5) == 0) n = $urandom_range(eff / 2, eff + 8);
         else n = $urandom_range(0, (2 * eff + 3 < 24) ? 2 * eff + 3 : 24);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 24) == 0) send_drain();
            else send_insert(pick_score(), pick_tie(), $urandom);
         end
         // some layers carry over into the next width setting
         if ($urandom_range(0, 4) != 0) begin
            send_drain();
            if ($urandom_range(0, 3) == 0) send_drain();
         end
         layer++;
      end
      send_drain();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_PREFER_HIGHER;
      csr_wdata  = '0;
      errors          = 0;
      items_sent      = 0;
      results_checked = 0;
      csr_writes      = 0;
      cycles          = 0;
      kept_count        = 0;
      next_seq          = '0;
      cfg_prefer_higher = 1'b0;
      cfg_random_ties   = 1'b0;
      cfg_beam_width    = BW_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_basics();
      test_tie_order();
      test_width_edges();
      test_width_lowered();
      test_full_beam();
      test_output_backpressure();
      test_random_layers();
      wait_idle();

      $display("covered %0d beats in, %0d result beats checked, %0d register writes",
               items_sent, results_checked, csr_writes);
      $display("widths 0 to 127, both score orders, tie tokens on and off, stalls on both sides");
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
